// ===== rtl/jsq_pkg.sv =====
package jsq_pkg;

  // Queue/server pairs, entries per queue, longest service length
  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_SERVICE = 255;

  // Derived widths
  localparam int QIW = $clog2(NUM_QUEUES);   // queue index
  localparam int PW  = $clog2(QUEUE_DEPTH);  // position inside one queue
  localparam int LW  = PW + 1;               // queue length, 0..QUEUE_DEPTH
  localparam int AW  = QIW + PW;             // store address
  localparam int BW  = 9;                    // busy countdown, 0..MAX_SERVICE+1
  localparam int CW  = 4;                    // active_queues register
  localparam int WTW = 10;                   // waiting_total

  // Request codes
  typedef enum logic [1:0] {
    REQ_ARRIVE   = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

endpackage

// ===== rtl/join_shortest_queue_dispatcher.sv =====
// Join-shortest-queue dispatcher: several FIFO queues, each with a server.
// Input channel: raise start with in_req_type / in_service_ticks; the beat is
// taken at a rising edge where start is high and busy is low. Arrive puts the
// current tick on the queue picked by the join rule, dispatch serves the first
// free server with a waiting customer, tick counts busy servers down and
// advances time.
// Result channel: out_valid is high for exactly one cycle per accepted beat and
// carries all result fields; the receiver cannot stall, so it must take it.
// Steps after the accepting edge: arrive S_ARR, S_ENQ, S_FIN; dispatch
// S_DSEL, S_DRD, S_DST, S_FIN (S_DSEL, S_FIN when no free server has a
// customer); tick S_TICK, S_FIN; unused code S_FIN only. Busy drops in the
// strobe cycle, so a new beat may be accepted at the edge that ends it; a
// beat is not taken before the last one is through. The stamp memory read
// is registered, and the queue scan and the 48-bit wait accumulation each
// take a sequencer step.
// Configuration: cfg_valid/cfg_ready write active_queues (always ready);
// write it only while the block is idle.
// Reset (rst_n low at a clock edge) empties all queues, frees all servers,
// sets the tick to one, clears the statistics and sets active_queues to one.
// The stamp memory is not cleared; only written entries are read.
module join_shortest_queue_dispatcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_service_ticks,
  output logic                          out_valid,
  output logic [jsq_pkg::QIW-1:0]       out_queue_index,
  output logic                          out_dispatched,
  output logic                          out_dropped,
  output logic [31:0]                   out_wait_ticks,
  output logic [31:0]                   out_served_count,
  output logic [47:0]                   out_total_wait,
  output logic [31:0]                   out_max_wait,
  output logic [jsq_pkg::WTW-1:0]       out_waiting_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jsq_pkg::CW-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR,
    S_ENQ,
    S_DSEL,
    S_DRD,
    S_DST,
    S_TICK,
    S_FIN
  } state_t;

  state_t state_r;

  // Per-queue control state
  logic [jsq_pkg::PW-1:0]  head_r [jsq_pkg::NUM_QUEUES];
  logic [jsq_pkg::LW-1:0]  len_r  [jsq_pkg::NUM_QUEUES];
  logic [jsq_pkg::BW-1:0]  srv_r  [jsq_pkg::NUM_QUEUES];

  // Global state
  logic [31:0]             tick_r;
  logic [31:0]             served_r;
  logic [47:0]             wsum_r;
  logic [31:0]             wpeak_r;
  logic [jsq_pkg::CW-1:0]  active_r;

  // Per-item working registers
  logic [7:0]              svc_r;
  logic [jsq_pkg::QIW-1:0] q_r;
  logic                    disp_r;
  logic                    drop_r;
  logic [31:0]             wt_r;

  // Stamp memory
  logic [31:0]             store_mem [jsq_pkg::NUM_QUEUES * jsq_pkg::QUEUE_DEPTH];
  logic [31:0]             stamp_r;
  logic                    mem_we;
  logic [jsq_pkg::AW-1:0]  mem_waddr;
  logic                    mem_re;
  logic [jsq_pkg::AW-1:0]  mem_raddr;

  // Output registers
  logic                    out_valid_r;
  logic [jsq_pkg::QIW-1:0] out_qidx_r;
  logic                    out_disp_r;
  logic                    out_drop_r;
  logic [31:0]             out_wt_r;
  logic [31:0]             out_served_r;
  logic [47:0]             out_wsum_r;
  logic [31:0]             out_wpeak_r;
  logic [jsq_pkg::WTW-1:0] out_wtot_r;

  logic [jsq_pkg::CW-1:0]  live_n;
  logic [jsq_pkg::QIW-1:0] best_q;
  logic [jsq_pkg::LW-1:0]  best_len;
  logic [jsq_pkg::QIW-1:0] pick_q;
  logic                    pick_hit;
  logic [jsq_pkg::QIW-1:0] find_q;
  logic                    find_hit;
  logic [7:0]              svc_c;
  logic [48:0]             wsum_add;
  logic [jsq_pkg::WTW-1:0] wtot_c;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);

  // Clamp the active count to 1..NUM_QUEUES
  always_comb begin
    live_n = active_r;
    if (active_r == '0) begin
      live_n = jsq_pkg::CW'(1);
    end else if (int'(active_r) > jsq_pkg::NUM_QUEUES) begin
      live_n = jsq_pkg::CW'(jsq_pkg::NUM_QUEUES);
    end
  end

  // Join rule: find the first shortest queue, then prefer the first free server whose queue is empty or at that minimum
  always_comb begin
    best_q   = '0;
    best_len = len_r[0];
    for (int k = 1; k < jsq_pkg::NUM_QUEUES; k++) begin
      if (k < int'(live_n) && len_r[k] < best_len) begin
        best_q   = jsq_pkg::QIW'(k);
        best_len = len_r[k];
      end
    end
    pick_hit = 1'b0;
    pick_q   = best_q;
    for (int k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
      if (!pick_hit && k < int'(live_n) && srv_r[k] == '0 &&
          (len_r[k] == '0 || (len_r[k] == best_len && best_len != '0))) begin
        pick_hit = 1'b1;
        pick_q   = jsq_pkg::QIW'(k);
      end
    end
  end

  // Dispatch rule: first free server with a waiting customer
  always_comb begin
    find_hit = 1'b0;
    find_q   = '0;
    for (int k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
      if (!find_hit && k < int'(live_n) && srv_r[k] == '0 && len_r[k] != '0) begin
        find_hit = 1'b1;
        find_q   = jsq_pkg::QIW'(k);
      end
    end
  end

  // Clamp the service length
  always_comb begin
    svc_c = svc_r;
    if (svc_r == '0) begin
      svc_c = 8'd1;
    end else if (int'(svc_r) > jsq_pkg::MAX_SERVICE) begin
      svc_c = 8'(jsq_pkg::MAX_SERVICE);
    end
  end

  assign wsum_add = {1'b0, wsum_r} + {17'd0, wt_r};

  // Count waiting customers over the active queues
  always_comb begin
    wtot_c = '0;
    for (int k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
      if (k < int'(live_n)) begin
        wtot_c = wtot_c + jsq_pkg::WTW'(len_r[k]);
      end
    end
  end

  // Memory port control
  assign mem_we    = (state_r == S_ENQ) && !drop_r;
  assign mem_waddr = {q_r, head_r[q_r] + len_r[q_r][jsq_pkg::PW-1:0]};
  assign mem_re    = (state_r == S_DSEL) && find_hit;
  assign mem_raddr = {find_q, head_r[find_q]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= tick_r;
    end
    if (mem_re) begin
      stamp_r <= store_mem[mem_raddr];
    end
  end

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= jsq_pkg::CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_data;
    end
  end

  // Sequencer, queue state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd1;
      served_r    <= '0;
      wsum_r      <= '0;
      wpeak_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
        head_r[k] <= '0;
        len_r[k]  <= '0;
        srv_r[k]  <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            svc_r  <= in_service_ticks;
            q_r    <= '0;
            disp_r <= 1'b0;
            drop_r <= 1'b0;
            wt_r   <= '0;
            case (jsq_pkg::req_t'(in_req_type))
              jsq_pkg::REQ_ARRIVE:   state_r <= S_ARR;
              jsq_pkg::REQ_DISPATCH: state_r <= S_DSEL;
              jsq_pkg::REQ_TICK:     state_r <= S_TICK;
              default:               state_r <= S_FIN;
            endcase
          end
        end
        // Hold the chosen queue and its full flag
        S_ARR: begin
          q_r     <= pick_q;
          drop_r  <= (int'(len_r[pick_q]) >= jsq_pkg::QUEUE_DEPTH);
          state_r <= S_ENQ;
        end
        // Stamp is written by the memory port; grow the queue
        S_ENQ: begin
          if (!drop_r) begin
            len_r[q_r] <= len_r[q_r] + 1'b1;
          end
          state_r <= S_FIN;
        end
        // Select the server; the head stamp read is issued here
        S_DSEL: begin
          q_r     <= find_hit ? find_q : '0;
          disp_r  <= find_hit;
          state_r <= find_hit ? S_DRD : S_FIN;
        end
        // Pop the head, start service, compute the wait
        S_DRD: begin
          head_r[q_r] <= head_r[q_r] + 1'b1;
          len_r[q_r]  <= len_r[q_r] - 1'b1;
          srv_r[q_r]  <= jsq_pkg::BW'(svc_c) + 1'b1;
          wt_r        <= tick_r - stamp_r;
          if (served_r != '1) begin
            served_r <= served_r + 1'b1;
          end
          state_r <= S_DST;
        end
        // Accumulate wait statistics
        S_DST: begin
          wsum_r <= wsum_add[48] ? '1 : wsum_add[47:0];
          if (wt_r > wpeak_r) begin
            wpeak_r <= wt_r;
          end
          state_r <= S_FIN;
        end
        // Count every busy server down and advance time
        S_TICK: begin
          for (int k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
            if (srv_r[k] != '0) begin
              srv_r[k] <= srv_r[k] - 1'b1;
            end
          end
          tick_r  <= tick_r + 1'b1;
          state_r <= S_FIN;
        end
        // Present the result beat
        S_FIN: begin
          out_valid_r  <= 1'b1;
          out_qidx_r   <= q_r;
          out_disp_r   <= disp_r;
          out_drop_r   <= drop_r;
          out_wt_r     <= wt_r;
          out_served_r <= served_r;
          out_wsum_r   <= wsum_r;
          out_wpeak_r  <= wpeak_r;
          out_wtot_r   <= wtot_c;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_queue_index   = out_qidx_r;
  assign out_dispatched    = out_disp_r;
  assign out_dropped       = out_drop_r;
  assign out_wait_ticks    = out_wt_r;
  assign out_served_count  = out_served_r;
  assign out_total_wait    = out_wsum_r;
  assign out_max_wait      = out_wpeak_r;
  assign out_waiting_total = out_wtot_r;

endmodule

// ===== dv/join_shortest_queue_dispatcher_tb.sv =====
`timescale 1ns / 100ps

module join_shortest_queue_dispatcher_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_GAP     = 16;

  // Active-queue setting and stimulus mix of each random phase, first phase in
  // the top nibble / top two bits: 0 arrive-heavy, 1 balanced, 2 drain-heavy
  localparam int              NUM_PHASES  = 10;
  localparam logic [39:0]     ACTIVE_PLAN = 40'h0F391582C7;
  localparam logic [19:0]     MIX_PLAN    = 20'b00_01_00_01_00_10_01_00_01_10;
  localparam int              PHASE_BEATS = 200;

  typedef struct {
    jsq_pkg::req_t req;
    logic [7:0]    svc;
    int            gap;
    bit            hush;   // hold the beat until every result is back
  } request_t;

  typedef struct packed {
    logic [jsq_pkg::QIW-1:0] queue_index;
    logic                    dispatched;
    logic                    dropped;
    logic [31:0]             wait_ticks;
    logic [31:0]             served_count;
    logic [47:0]             total_wait;
    logic [31:0]             max_wait;
    logic [jsq_pkg::WTW-1:0] waiting_total;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_req_type = 2'd0;
  logic [7:0]              in_service_ticks = 8'd0;
  logic                    out_valid;
  logic [jsq_pkg::QIW-1:0] out_queue_index;
  logic                    out_dispatched;
  logic                    out_dropped;
  logic [31:0]             out_wait_ticks;
  logic [31:0]             out_served_count;
  logic [47:0]             out_total_wait;
  logic [31:0]             out_max_wait;
  logic [jsq_pkg::WTW-1:0] out_waiting_total;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [jsq_pkg::CW-1:0]  cfg_data = '0;

  join_shortest_queue_dispatcher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_service_ticks  (in_service_ticks),
    .out_valid         (out_valid),
    .out_queue_index   (out_queue_index),
    .out_dispatched    (out_dispatched),
    .out_dropped       (out_dropped),
    .out_wait_ticks    (out_wait_ticks),
    .out_served_count  (out_served_count),
    .out_total_wait    (out_total_wait),
    .out_max_wait      (out_max_wait),
    .out_waiting_total (out_waiting_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow state of the dispatcher
  logic [31:0]            stamp_mem [jsq_pkg::NUM_QUEUES*jsq_pkg::QUEUE_DEPTH];
  logic [jsq_pkg::PW-1:0] q_head    [jsq_pkg::NUM_QUEUES];
  logic [jsq_pkg::LW-1:0] q_len     [jsq_pkg::NUM_QUEUES];
  logic [jsq_pkg::BW-1:0] srv_left  [jsq_pkg::NUM_QUEUES];
  logic [31:0]            tick_now;
  logic [31:0]            served_n;
  logic [47:0]            wait_acc;
  logic [31:0]            wait_top;
  logic [jsq_pkg::CW-1:0] active_cfg;

  request_t request_fifo [$];
  outcome_t outcome_fifo [$];
  request_t cur_req;
  bit       holding = 1'b0;
  int       gap_cnt = 0;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;

  // Advance the shadow state by one beat and return the result it must give
  function automatic outcome_t predict_outcome(input request_t rq);
    outcome_t    r;
    int          n;
    int          k;
    int          best;
    int          pick;
    int          pos;
    bit          found;
    int          svc_c;
    int          sum;
    logic [jsq_pkg::LW-1:0] best_len;
    logic [31:0] stamp;
    logic [48:0] acc;
    r = '0;
    n = (active_cfg == 0) ? 1 :
        (active_cfg > jsq_pkg::NUM_QUEUES) ? jsq_pkg::NUM_QUEUES : int'(active_cfg);
    case (rq.req)
      jsq_pkg::REQ_ARRIVE: begin
        best = 0;
        best_len = q_len[0];
        for (k = 1; k < n; k++) begin
          if (q_len[k] < best_len) begin
            best = k;
            best_len = q_len[k];
          end
        end
        // prefer the first free server whose queue is empty or at the nonzero minimum
        pick = best;
        found = 1'b0;
        for (k = 0; k < n; k++) begin
          if (!found && srv_left[k] == 0 &&
              (q_len[k] == 0 || (q_len[k] == best_len && best_len != 0))) begin
            pick = k;
            found = 1'b1;
          end
        end
        r.queue_index = jsq_pkg::QIW'(pick);
        if (q_len[pick] >= jsq_pkg::QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          pos = (int'(q_head[pick]) + int'(q_len[pick])) % jsq_pkg::QUEUE_DEPTH;
          stamp_mem[pick*jsq_pkg::QUEUE_DEPTH + pos] = tick_now;
          q_len[pick] = q_len[pick] + 1'b1;
        end
      end
      jsq_pkg::REQ_DISPATCH: begin
        pick = 0;
        found = 1'b0;
        for (k = 0; k < n; k++) begin
          if (!found && srv_left[k] == 0 && q_len[k] != 0) begin
            pick = k;
            found = 1'b1;
          end
        end
        if (found) begin
          stamp = stamp_mem[pick*jsq_pkg::QUEUE_DEPTH + int'(q_head[pick])];
          q_head[pick] = jsq_pkg::PW'((int'(q_head[pick]) + 1) % jsq_pkg::QUEUE_DEPTH);
          q_len[pick] = q_len[pick] - 1'b1;
          r.wait_ticks = tick_now - stamp;
          if (served_n != '1) served_n = served_n + 32'd1;
          // saturate the wait sum at its 48-bit ceiling
          acc = {1'b0, wait_acc} + {17'd0, r.wait_ticks};
          wait_acc = acc[48] ? '1 : acc[47:0];
          if (r.wait_ticks > wait_top) wait_top = r.wait_ticks;
          svc_c = (rq.svc == 0) ? 1 : int'(rq.svc);
          if (svc_c > jsq_pkg::MAX_SERVICE) svc_c = jsq_pkg::MAX_SERVICE;
          srv_left[pick] = jsq_pkg::BW'(svc_c + 1);
          r.queue_index = jsq_pkg::QIW'(pick);
          r.dispatched = 1'b1;
        end
      end
      jsq_pkg::REQ_TICK: begin
        // count down every server, active or not
        for (k = 0; k < jsq_pkg::NUM_QUEUES; k++) begin
          if (srv_left[k] != 0) srv_left[k] = srv_left[k] - 1'b1;
        end
        tick_now = tick_now + 32'd1;
      end
      default: begin
      end
    endcase
    sum = 0;
    for (k = 0; k < n; k++) sum += int'(q_len[k]);
    r.served_count = served_n;
    r.total_wait = wait_acc;
    r.max_wait = wait_top;
    r.waiting_total = jsq_pkg::WTW'(sum);
    return r;
  endfunction

  // Driver: present one beat at a time, with its gap, and predict on acceptance
  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (!rst_n) begin
      next_start = 1'b0;
      holding = 1'b0;
      gap_cnt = 0;
    end else begin
      if (start && !busy) begin
        outcome_fifo.push_back(predict_outcome(cur_req));
        holding = 1'b0;
        next_start = 1'b0;
        gap_cnt = 0;
      end
      if (!holding && request_fifo.size() != 0) begin
        if (gap_cnt < request_fifo[0].gap) begin
          gap_cnt++;
        end else if (!(request_fifo[0].hush && outcome_fifo.size() != 0)) begin
          cur_req = request_fifo.pop_front();
          in_req_type <= cur_req.req;
          in_service_ticks <= cur_req.svc;
          next_start = 1'b1;
          holding = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid) begin
      got = '{out_queue_index, out_dispatched, out_dropped, out_wait_ticks,
              out_served_count, out_total_wait, out_max_wait, out_waiting_total};
      if (outcome_fifo.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with nothing predicted", $realtime);
      end else begin
        want = outcome_fifo.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"%0t: mismatch exp q=%0d disp=%0b drop=%0b wait=%0d",
                      " served=%0d total=%0d max=%0d waiting=%0d"},
                     $realtime, want.queue_index, want.dispatched, want.dropped,
                     want.wait_ticks, want.served_count, want.total_wait,
                     want.max_wait, want.waiting_total);
            $display({"%0t:          got q=%0d disp=%0b drop=%0b wait=%0d",
                      " served=%0d total=%0d max=%0d waiting=%0d"},
                     $realtime, got.queue_index, got.dispatched, got.dropped,
                     got.wait_ticks, got.served_count, got.total_wait,
                     got.max_wait, got.waiting_total);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_beat(input jsq_pkg::req_t req, input logic [7:0] svc, input int gap,
                          input bit hush);
    request_t rq;
    rq.req = req;
    rq.svc = svc;
    rq.gap = gap;
    rq.hush = hush;
    request_fifo.push_back(rq);
  endtask

  // Wait until every queued beat is taken and every result is back
  task automatic wait_idle();
    while (request_fifo.size() != 0 || holding || outcome_fifo.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(input logic [jsq_pkg::CW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_cfg = value;
  endtask

  // Queue one random phase: bursts without gaps mix at random with gapped bursts
  task automatic fill_phase(input int count, input logic [1:0] mix);
    int            i;
    int            roll;
    int            hush_at;
    int            burst_left;
    bit            burst_tight;
    jsq_pkg::req_t req;
    logic [7:0]    svc;
    hush_at = $urandom_range(0, count - 1);
    burst_left = 0;
    burst_tight = 1'b0;
    for (i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(5, 40);
        burst_tight = ($urandom_range(0, 2) == 0);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      case (mix)
        2'd0:    req = (roll < 75) ? jsq_pkg::REQ_ARRIVE :
                       (roll < 85) ? jsq_pkg::REQ_DISPATCH :
                       (roll < 97) ? jsq_pkg::REQ_TICK : jsq_pkg::REQ_NONE;
        2'd2:    req = (roll < 20) ? jsq_pkg::REQ_ARRIVE :
                       (roll < 65) ? jsq_pkg::REQ_DISPATCH :
                       (roll < 95) ? jsq_pkg::REQ_TICK : jsq_pkg::REQ_NONE;
        default: req = (roll < 40) ? jsq_pkg::REQ_ARRIVE :
                       (roll < 70) ? jsq_pkg::REQ_DISPATCH :
                       (roll < 95) ? jsq_pkg::REQ_TICK : jsq_pkg::REQ_NONE;
      endcase
      roll = $urandom_range(0, 7);
      svc = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      add_beat(req, svc, burst_tight ? 0 : int'($urandom_range(0, MAX_GAP)), i == hush_at);
    end
  endtask

  initial begin
    int p;
    // Reset shadow state
    for (p = 0; p < jsq_pkg::NUM_QUEUES; p++) begin
      q_head[p] = '0;
      q_len[p] = '0;
      srv_left[p] = '0;
    end
    tick_now = 32'd1;
    served_n = '0;
    wait_acc = '0;
    wait_top = '0;
    active_cfg = 4'd1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // One queue after reset: empty dispatch, unused code, clamp of zero service
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd5, 0, 1'b0);
    add_beat(jsq_pkg::REQ_TICK, 8'd0, 1, 1'b0);
    add_beat(jsq_pkg::REQ_NONE, 8'd255, 0, 1'b0);
    add_beat(jsq_pkg::REQ_ARRIVE, 8'd0, 2, 1'b0);
    add_beat(jsq_pkg::REQ_ARRIVE, 8'd0, 0, 1'b0);
    add_beat(jsq_pkg::REQ_TICK, 8'd0, 0, 1'b0);
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd0, 3, 1'b0);
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd9, 0, 1'b0);
    add_beat(jsq_pkg::REQ_TICK, 8'd0, 0, 1'b0);
    add_beat(jsq_pkg::REQ_TICK, 8'd0, 0, 1'b0);
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd255, 0, 1'b1);
    wait_idle();

    // All eight queues: spread over free servers, then fall back to the shortest
    write_active(4'd8);
    for (p = 0; p < 9; p++)
      add_beat(jsq_pkg::REQ_ARRIVE, 8'($urandom_range(0, 255)), p % 3, 1'b0);
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd255, 0, 1'b0);
    add_beat(jsq_pkg::REQ_DISPATCH, 8'd1, 1, 1'b0);
    add_beat(jsq_pkg::REQ_TICK, 8'd0, 0, 1'b0);
    add_beat(jsq_pkg::REQ_ARRIVE, 8'd0, 0, 1'b0);
    wait_idle();

    // Random phases over the planned settings, extremes included
    for (p = 0; p < NUM_PHASES; p++) begin
      write_active(ACTIVE_PLAN[4*(NUM_PHASES-1-p) +: 4]);
      fill_phase(PHASE_BEATS, MIX_PLAN[2*(NUM_PHASES-1-p) +: 2]);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outcome_fifo.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
